[design/assert_macros.svh]
// assertion macros used by complex_arith_unit_top.sv
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, off while reset is asserted
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[design/cau_pkg.sv]
// types, constants and the divide step of the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // one quotient bit per divider stage
    localparam int unsigned DivSteps = 48;

    localparam logic signed [31:0] ResMax = 32'sh7fff_ffff;
    localparam logic signed [31:0] ResMin = 32'sh8000_0000;

    // partial remainder and numerator/quotient shift word
    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] w;
    } div_lane_t;

    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        sat;
    } side_t;

    typedef struct packed {
        div_lane_t   re;
        div_lane_t   im;
        logic [31:0] den;
        side_t       side;
    } div_item_t;

    typedef struct packed {
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        dz;
        logic        sat;
    } result_t;

    // one restoring division step
    function automatic div_lane_t div_step(div_lane_t l, logic [31:0] den);
        logic [32:0] trial;
        div_lane_t   r;
        trial = {l.rem, l.w[47]};
        if (trial >= {1'b0, den})
        begin
            trial = trial - {1'b0, den};
            r.w   = {l.w[46:0], 1'b1};
        end
        else
        begin
            r.w   = {l.w[46:0], 1'b0};
        end
        r.rem = trial[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[design/cau_pre.sv]
// front stages: partial products and operand sums, then combine, clamp and divider setup
// depends on cau_pkg
`default_nettype none

module cau_pre (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic signed [15:0] a_real,
    input  wire logic signed [15:0] a_imag,
    input  wire logic signed [15:0] b_real,
    input  wire logic signed [15:0] b_imag,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cau_pkg::div_item_t      out_item
);

    logic               v1_reg;
    cau_pkg::op_t       op1_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bbr_reg, p_bbi_reg;
    logic signed [16:0] sre_reg, sim_reg;
    logic signed [16:0] sre_next, sim_next;

    logic               v2_reg;
    cau_pkg::div_item_t item_reg, item_next;

    logic rdy1, rdy2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        if (cau_pkg::op_t'(cmd) == cau_pkg::OP_SUB)
        begin
            sre_next = {a_real[15], a_real} - {b_real[15], b_real};
            sim_next = {a_imag[15], a_imag} - {b_imag[15], b_imag};
        end
        else
        begin
            sre_next = {a_real[15], a_real} + {b_real[15], b_real};
            sim_next = {a_imag[15], a_imag} + {b_imag[15], b_imag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg   <= cau_pkg::op_t'(cmd);
            p_rr_reg  <= a_real * b_real;
            p_ii_reg  <= a_imag * b_imag;
            p_ri_reg  <= a_real * b_imag;
            p_ir_reg  <= a_imag * b_real;
            p_bbr_reg <= b_real * b_real;
            p_bbi_reg <= b_imag * b_imag;
            sre_reg   <= sre_next;
            sim_reg   <= sim_next;
        end
        if (rdy2)
        begin
            item_reg <= item_next;
        end
    end

    logic signed [32:0] mre, mim, nre, nim;
    logic [31:0]        are, aim;
    logic               sat_re, sat_im;
    logic [31:0]        cre, cim;

    always_comb
    begin
        mre = {p_rr_reg[31], p_rr_reg} - {p_ii_reg[31], p_ii_reg};
        mim = {p_ri_reg[31], p_ri_reg} + {p_ir_reg[31], p_ir_reg};
        nre = {p_rr_reg[31], p_rr_reg} + {p_ii_reg[31], p_ii_reg};
        nim = {p_ir_reg[31], p_ir_reg} - {p_ri_reg[31], p_ri_reg};
        are = nre[32] ? 32'(-nre) : nre[31:0];
        aim = nim[32] ? 32'(-nim) : nim[31:0];

        sat_re = 1'b0;
        sat_im = 1'b0;
        cre    = mre[31:0];
        cim    = mim[31:0];
        if (mre > 33'(cau_pkg::ResMax))
        begin
            cre    = cau_pkg::ResMax;
            sat_re = 1'b1;
        end
        else if (mre < 33'(cau_pkg::ResMin))
        begin
            cre    = cau_pkg::ResMin;
            sat_re = 1'b1;
        end
        if (mim > 33'(cau_pkg::ResMax))
        begin
            cim    = cau_pkg::ResMax;
            sat_im = 1'b1;
        end
        else if (mim < 33'(cau_pkg::ResMin))
        begin
            cim    = cau_pkg::ResMin;
            sat_im = 1'b1;
        end

        item_next.re.rem      = '0;
        item_next.re.w        = {are, 16'd0};
        item_next.im.rem      = '0;
        item_next.im.w        = {aim, 16'd0};
        item_next.den         = p_bbr_reg[31:0] + p_bbi_reg[31:0];
        item_next.side.is_div = (op1_reg == cau_pkg::OP_DIV);
        item_next.side.dz     = (p_bbr_reg == 32'sd0) && (p_bbi_reg == 32'sd0);
        item_next.side.neg_re = nre[32];
        item_next.side.neg_im = nim[32];

        unique case (op1_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                item_next.side.res_re = {{7{sre_reg[16]}}, sre_reg, 8'd0};
                item_next.side.res_im = {{7{sim_reg[16]}}, sim_reg, 8'd0};
                item_next.side.sat    = 1'b0;
            end
            cau_pkg::OP_MUL:
            begin
                item_next.side.res_re = cre;
                item_next.side.res_im = cim;
                item_next.side.sat    = sat_re | sat_im;
            end
            default:
            begin
                item_next.side.res_re = '0;
                item_next.side.res_im = '0;
                item_next.side.sat    = 1'b0;
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[design/cau_div.sv]
// pipelined restoring divider, one quotient bit per stage, both parts in parallel
// depends on cau_pkg
`default_nettype none

module cau_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cau_pkg::div_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cau_pkg::div_item_t      out_item
);

    localparam int unsigned N = cau_pkg::DivSteps;

    cau_pkg::div_item_t st_reg [N];
    logic [N-1:0]       v_reg;
    logic [N:0]         rdy;

    assign rdy[N] = out_ready;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        cau_pkg::div_item_t cur, st_next;
        logic               cur_v;

        if (i == 0)
        begin : g_first
            assign cur   = in_item;
            assign cur_v = in_valid;
        end
        else
        begin : g_rest
            assign cur   = st_reg[i-1];
            assign cur_v = v_reg[i-1];
        end

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_comb
        begin
            st_next    = cur;
            st_next.re = cau_pkg::div_step(cur.re, cur.den);
            st_next.im = cau_pkg::div_step(cur.im, cur.den);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                v_reg[i] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_item  = st_reg[N-1];

endmodule

`default_nettype wire

[design/cau_post.sv]
// back stage: sign and clamp of quotients, result select, output register
// depends on cau_pkg
`default_nettype none

module cau_post (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cau_pkg::div_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cau_pkg::result_t        out_res
);

    logic             v_reg;
    cau_pkg::result_t res_reg, res_next;

    function automatic logic [32:0] fix_quot(logic neg, logic [47:0] q);
        logic [32:0] r;
        if (!neg)
        begin
            if (q > 48'h0000_7fff_ffff)
                r = {1'b1, cau_pkg::ResMax};
            else
                r = {1'b0, q[31:0]};
        end
        else
        begin
            if (q > 48'h0000_8000_0000)
                r = {1'b1, cau_pkg::ResMin};
            else
                r = {1'b0, 32'(~q[31:0] + 32'd1)};
        end
        return r;
    endfunction

    logic [32:0] qre, qim;

    always_comb
    begin
        qre = fix_quot(in_item.side.neg_re, in_item.re.w);
        qim = fix_quot(in_item.side.neg_im, in_item.im.w);
        if (!in_item.side.is_div)
        begin
            res_next.res_re = in_item.side.res_re;
            res_next.res_im = in_item.side.res_im;
            res_next.dz     = 1'b0;
            res_next.sat    = in_item.side.sat;
        end
        else if (in_item.side.dz)
        begin
            res_next.res_re = '0;
            res_next.res_im = '0;
            res_next.dz     = 1'b1;
            res_next.sat    = 1'b0;
        end
        else
        begin
            res_next.res_re = qre[31:0];
            res_next.res_im = qim[31:0];
            res_next.dz     = 1'b0;
            res_next.sat    = qre[32] | qim[32];
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[design/complex_arith_unit_top.sv]
// complex arithmetic unit: add, subtract, multiply, divide of q8.8 operands
// depends on cau_pkg, cau_pre, cau_div, cau_post and assert_macros.svh
//
// usage
//   slave stream s_*: one transaction per operation, opcode in s_tuser,
//   operands a and b in s_tdata
//   master stream m_*: one transaction per operation, q16.16 result in
//   m_tdata, div_zero and saturated flags in m_tuser
//   pipeline: 2 front stages, 48 divider stages with one quotient bit each
//   and 1 output register; every opcode takes the same path,
//   so results leave in input order
//   throughput: one transaction per cycle while m_tready is high, set by the
//   divider pipeline, which accepts a new operand pair in every stage every cycle unless stalled
//   reset: rst_n low empties all stages at once, no transaction in flight
//   survives; no clearing pass is needed
//   stall: when m_tready is low, stages behind a full output register keep
//   filling any empty slots; s_tready drops only once every stage holds a
//   transaction, and nothing is lost or repeated
`default_nettype none

`include "assert_macros.svh"

module complex_arith_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // a_real[15:0], a_imag, b_real, b_imag
    input  wire logic [1:0]  s_tuser,  // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // res_real[31:0], res_imag
    output logic [1:0]       m_tuser   // div_zero, saturated
);

    // front to divider
    logic               pre_valid, pre_ready;
    cau_pkg::div_item_t pre_item;
    // divider to back stage
    logic               div_valid, div_ready;
    cau_pkg::div_item_t div_item;
    cau_pkg::result_t   res;

    cau_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .a_real    (s_tdata[15:0]),
        .a_imag    (s_tdata[31:16]),
        .b_real    (s_tdata[47:32]),
        .b_imag    (s_tdata[63:48]),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_item  (pre_item)
    );

    cau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_item   (pre_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    cau_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_item   (div_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.res_im, res.res_re};
    assign m_tuser = {res.sat, res.dz};

    // backpressure only reaches the input when the whole pipe is full
    `ASSERT_IMPLY(a_full_stall, !s_tready, m_tvalid && !m_tready, "input stalled with room left")
    // divide by zero gives zero and no clamp
    `ASSERT_IMPLY(a_dz_zero, m_tvalid && m_tuser[0],
        m_tdata == 64'd0 && !m_tuser[1], "bad div zero result")
    // a clamped result shows a limit value in one of its parts
    `ASSERT_CLK(a_sat_limit, m_tvalid && m_tuser[1] |->
        (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
        m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000),
        "saturated without limit value")

endmodule

`default_nettype wire

[sim/complex_arith_unit_checker.sv]
// checker for the complex arithmetic unit: watches both streams, predicts results
// depends on cau_pkg for the opcode type
`default_nettype none

module complex_arith_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               errors,
    output int               pending,
    output int               seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } cplx_res_t;

    cplx_res_t res_fifo[$];

    function automatic logic [31:0] clamp_part(longint v, ref logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic cplx_res_t calc_cplx(cau_pkg::op_t op, logic [63:0] d);
        longint ar, ai, br, bi, re, im, den;
        cplx_res_t r;
        logic sat;
        ar = longint'($signed(d[15:0]));
        ai = longint'($signed(d[31:16]));
        br = longint'($signed(d[47:32]));
        bi = longint'($signed(d[63:48]));
        re = 0;
        im = 0;
        sat = 1'b0;
        r.dz = 1'b0;
        unique case (op)
            cau_pkg::OP_ADD:
            begin
                re = (ar + br) * 256;
                im = (ai + bi) * 256;
            end
            cau_pkg::OP_SUB:
            begin
                re = (ar - br) * 256;
                im = (ai - bi) * 256;
            end
            cau_pkg::OP_MUL:
            begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    // sv integer division truncates toward zero
                    re = ((ar * br + ai * bi) * 65536) / den;
                    im = ((ai * br - ar * bi) * 65536) / den;
                end
            end
        endcase
        r.re = clamp_part(re, sat);
        r.im = clamp_part(im, sat);
        r.sat = sat;
        return r;
    endfunction

    initial
    begin
        errors = 0;
        seen = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        cplx_res_t e;
        if (rst_n && s_tvalid && s_tready)
            res_fifo.push_back(calc_cplx(cau_pkg::op_t'(s_tuser), s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            seen++;
            if (res_fifo.size() == 0)
            begin
                $error("result transaction with nothing expected: %h %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = res_fifo.pop_front();
                if (m_tdata[31:0] !== e.re)
                begin
                    $error("res_real: expected %h, got %h", e.re, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.im)
                begin
                    $error("res_imag: expected %h, got %h", e.im, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser[0] !== e.dz)
                begin
                    $error("div_zero: expected %b, got %b", e.dz, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.sat)
                begin
                    $error("saturated: expected %b, got %b", e.sat, m_tuser[1]);
                    errors++;
                end
            end
        end
        pending = res_fifo.size();
    end

endmodule

`default_nettype wire

[sim/complex_arith_unit_top_test.sv]
// testbench top for the complex arithmetic unit: clock, reset, stimulus, verdict
// depends on cau_pkg, complex_arith_unit_top and complex_arith_unit_checker
`default_nettype none

module complex_arith_unit_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // a_real, a_imag, b_real, b_imag
    logic [1:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // res_real, res_imag
    logic [1:0]  m_tuser;   // div_zero, saturated
    int          errors;
    int          pending;
    int          seen;

    // idle percentages for sender and receiver, changed per phase
    int          send_idle;
    int          recv_idle;
    int          n_sent;

    complex_arith_unit_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    complex_arith_unit_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .seen     (seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stall at the configured rate
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // one operation transaction, with random idle cycles ahead of it
    task automatic send_op(cau_pkg::op_t op, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bi, br, ai, ar};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // operand value biased toward edge values and zero
    function automatic logic [15:0] pick_val();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_ops(int count);
        cau_pkg::op_t op;
        logic [15:0] br, bi;
        for (int i = 0; i < count; i++)
        begin
            op = cau_pkg::op_t'($urandom_range(3));
            br = pick_val();
            bi = pick_val();
            // divide by zero now and then
            if (op == cau_pkg::OP_DIV && $urandom_range(9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_op(op, pick_val(), pick_val(), br, bi);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cau_pkg::OP_ADD;
        send_idle = 0;
        recv_idle = 0;
        n_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every opcode, divide by zero, saturation
        send_op(cau_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_op(cau_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(cau_pkg::OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_op(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_op(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(cau_pkg::OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        send_op(cau_pkg::OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_op(cau_pkg::OP_MUL, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
        send_op(cau_pkg::OP_DIV, 16'h1234, 16'hfedc, 16'h0000, 16'h0000);
        send_op(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_op(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
        send_op(cau_pkg::OP_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
        send_op(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h8000, 16'h8000);
        send_op(cau_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
        send_op(cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_op(cau_pkg::OP_ADD, 16'hffff, 16'h0000, 16'h0001, 16'hffff);
        // pause until every expected result has come
        drain();

        // random phases: free flow, slow sender, slow receiver, both slow
        random_ops(300);
        send_idle = 83;
        random_ops(150);
        send_idle = 0;
        recv_idle = 83;
        random_ops(200);
        send_idle = 10;
        recv_idle = 10;
        random_ops(200);
        drain();
        recv_idle = 0;
        repeat (60) @(posedge clk);

        $display("ran %0d operations (add, sub, mul, div incl. divide by zero), %0d results",
                 n_sent, seen);
        $display("idle phases: none, sender 83%%, receiver 83%%, both 10%%");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[complex_arith_unit_top.f]
+incdir+design
design/cau_pkg.sv
design/cau_pre.sv
design/cau_div.sv
design/cau_post.sv
design/complex_arith_unit_top.sv
sim/complex_arith_unit_checker.sv
sim/complex_arith_unit_top_test.sv
